### sv/stdt_pkg.sv
package stdt_pkg;

  localparam int unsigned MaxBuckets = 1024;
  localparam int unsigned MaxEntries = 512;
  localparam int unsigned MaxDepth   = 32;

  localparam int unsigned BktW  = $clog2(MaxBuckets);      // bucket index
  localparam int unsigned EntW  = $clog2(MaxEntries);      // entry slot
  localparam int unsigned DepW  = $clog2(MaxDepth);        // frame index in a trace
  localparam int unsigned LenW  = DepW + 1;                // trace length, 0..MaxDepth
  localparam int unsigned CntW  = EntW + 1;                // entries used, 0..MaxEntries
  localparam int unsigned FrmAW = EntW + DepW;             // entry frame store address
  localparam int unsigned BufAW = DepW + 1;                // two trace buffers
  localparam int unsigned BcW   = 11;                      // bucket_count register
  localparam int unsigned FlW   = 15;                      // frame_limit register
  localparam int unsigned CfgW  = 15;

  localparam logic CfgBucketCount = 1'b0;
  localparam logic CfgFrameLimit  = 1'b1;

  localparam logic KindFind = 1'b0;
  localparam logic KindAdd  = 1'b1;

  localparam logic [1:0] StFound    = 2'd0;
  localparam logic [1:0] StAdded    = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StFailed   = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [31:0] frame;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  entry_index;
    logic [31:0] hit_count;
    logic [5:0]  trace_length;
    logic [31:0] total_hits;
    logic [9:0]  total_traces;
  } out_item_t;

  // One finished trace waiting for the chain walk.
  typedef struct packed {
    logic            kind;
    logic [31:0]     hash;
    logic [LenW-1:0] len;
    logic            too_long;
    logic            bank;
  } desc_t;

  typedef struct packed {
    logic             en;
    logic [BufAW-1:0] addr;
    logic [31:0]      data;
  } buf_wr_t;

  typedef struct packed {
    logic clearing;
    logic release_bank;
  } back_stat_t;

endpackage

### sv/stdt_front.sv
module stdt_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  stdt_pkg::in_item_t    in_data_i,
  input  stdt_pkg::back_stat_t  back_stat_i,
  output stdt_pkg::buf_wr_t     buf_wr_o,
  output logic                  push_o,
  output stdt_pkg::desc_t       push_data_o
);

  logic [31:0]               hash_q, hash_d;
  logic [stdt_pkg::LenW-1:0] len_q, len_d;
  logic                      long_q, long_d;
  logic                      bank_q, bank_d;
  logic [1:0]                busy_q, busy_d;
  logic                      acc;
  logic                      room;
  logic [31:0]               hash_n;
  logic [stdt_pkg::LenW-1:0] len_n;

  assign in_ready_o = (busy_q != 2'd2) && !back_stat_i.clearing;
  assign acc        = in_valid_i && in_ready_o;
  assign room       = len_q != stdt_pkg::LenW'(stdt_pkg::MaxDepth);
  assign hash_n     = hash_q + {16'd0, in_data_i.frame[15:0] ^ in_data_i.frame[31:16]};
  assign len_n      = room ? len_q + 1'b1 : len_q;

  assign buf_wr_o.en   = acc && room;
  assign buf_wr_o.addr = {bank_q, len_q[stdt_pkg::DepW-1:0]};
  assign buf_wr_o.data = in_data_i.frame;

  assign push_o               = acc && in_data_i.last;
  assign push_data_o.kind     = in_data_i.kind;
  assign push_data_o.hash     = hash_n;
  assign push_data_o.len      = len_n;
  assign push_data_o.too_long = long_q || !room;
  assign push_data_o.bank     = bank_q;

  always_comb begin
    hash_d = hash_q;
    len_d  = len_q;
    long_d = long_q;
    bank_d = bank_q;
    if (acc) begin
      if (in_data_i.last) begin
        hash_d = '0;
        len_d  = '0;
        long_d = 1'b0;
        bank_d = !bank_q;
      end else begin
        hash_d = hash_n;
        len_d  = len_n;
        long_d = long_q || !room;
      end
    end
    busy_d = busy_q + {1'b0, push_o} - {1'b0, back_stat_i.release_bank};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
      len_q  <= '0;
      long_q <= 1'b0;
      bank_q <= 1'b0;
      busy_q <= '0;
    end else begin
      hash_q <= hash_d;
      len_q  <= len_d;
      long_q <= long_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

endmodule

### sv/stdt_queue.sv
module stdt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  stdt_pkg::desc_t push_data_i,
  input  logic            pop_i,
  output logic            valid_o,
  output stdt_pkg::desc_t data_o
);

  stdt_pkg::desc_t slot_q [2];
  logic            wptr_q, rptr_q;
  logic [1:0]      cnt_q;

  assign valid_o = cnt_q != 2'd0;
  assign data_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

### sv/stdt_back.sv
module stdt_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [stdt_pkg::BcW-1:0] bucket_count_i,
  input  logic [stdt_pkg::FlW-1:0] frame_limit_i,
  input  stdt_pkg::buf_wr_t        buf_wr_i,
  input  logic                     q_valid_i,
  input  stdt_pkg::desc_t          q_data_i,
  output logic                     q_pop_o,
  output stdt_pkg::back_stat_t     stat_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output stdt_pkg::out_item_t      out_data_o
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SDiv   = 4'd1;
  localparam logic [3:0] SHead  = 4'd2;
  localparam logic [3:0] SHWait = 4'd3;
  localparam logic [3:0] SWalk  = 4'd4;
  localparam logic [3:0] SEWait = 4'd5;
  localparam logic [3:0] SCRd   = 4'd6;
  localparam logic [3:0] SCChk  = 4'd7;
  localparam logic [3:0] SHit   = 4'd8;
  localparam logic [3:0] SMiss  = 4'd9;
  localparam logic [3:0] SCpRd  = 4'd10;
  localparam logic [3:0] SCpWr  = 4'd11;
  localparam logic [3:0] SIns   = 4'd12;
  localparam logic [3:0] SDone  = 4'd13;

  localparam int unsigned BktW = stdt_pkg::BktW;
  localparam int unsigned EntW = stdt_pkg::EntW;
  localparam int unsigned DepW = stdt_pkg::DepW;
  localparam int unsigned LenW = stdt_pkg::LenW;

  // Memories: trace buffers, bucket heads ({valid, slot}), entry fields.
  logic [31:0]     buf_mem  [2 * stdt_pkg::MaxDepth];
  logic [EntW:0]   head_mem [stdt_pkg::MaxBuckets];
  logic [EntW:0]   nxt_mem  [stdt_pkg::MaxEntries];
  logic [LenW-1:0] elen_mem [stdt_pkg::MaxEntries];
  logic [31:0]     ecnt_mem [stdt_pkg::MaxEntries];
  logic [31:0]     frm_mem  [stdt_pkg::MaxEntries * stdt_pkg::MaxDepth];

  logic [31:0]     buf_rd, frm_rd, ecnt_rd;
  logic [EntW:0]   head_rd, nxt_rd;
  logic [LenW-1:0] elen_rd;

  logic [stdt_pkg::BufAW-1:0] buf_ra;
  logic [stdt_pkg::FrmAW-1:0] frm_ra;
  logic [EntW-1:0]            ent_ra;

  logic                       head_we;
  logic [BktW-1:0]            head_wa;
  logic [EntW:0]              head_wd;
  logic                       frm_we, ent_we, cnt_we;
  logic [31:0]                cnt_wd;

  logic [3:0]          st_q, st_d;
  stdt_pkg::desc_t     desc_q, desc_d;
  logic [stdt_pkg::BcW-1:0] bkts_q, bkts_d;
  logic [31:0]         dvd_q, dvd_d;
  logic [BktW-1:0]     rem_q, rem_d;
  logic [4:0]          bit_q, bit_d;
  logic [EntW:0]       head_q, head_d;
  logic [EntW-1:0]     cur_q, cur_d;
  logic                curv_q, curv_d;
  logic [EntW:0]       nxt_q, nxt_d;
  logic [31:0]         cnt_q, cnt_d;
  logic [DepW-1:0]     idx_q, idx_d;
  logic [stdt_pkg::CntW-1:0] used_q, used_d;
  logic [stdt_pkg::FlW-1:0]  fused_q, fused_d;
  logic [31:0]         hits_q, hits_d;
  stdt_pkg::out_item_t pend_q, pend_d;
  stdt_pkg::out_item_t res_q, res_d;
  logic                resv_q, resv_d;
  logic                clr_q, clr_d;
  logic [BktW-1:0]     clra_q, clra_d;

  logic [BktW:0]       trial;
  logic [BktW:0]       trial_sub;
  logic                last_idx;
  logic [15:0]         fsum;
  logic                fail;
  logic [31:0]         cnt_inc;
  logic [31:0]         hits_inc;

  assign trial     = {rem_q, dvd_q[31]};
  assign trial_sub = trial - bkts_q;
  assign last_idx  = {1'b0, idx_q} == desc_q.len - 1'b1;
  assign fsum      = {1'b0, fused_q} + {{(16 - LenW){1'b0}}, desc_q.len};
  assign fail      = desc_q.too_long || used_q[EntW] ||
                     ((frame_limit_i != '0) && (fsum > {1'b0, frame_limit_i}));
  assign cnt_inc   = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
  assign hits_inc  = (hits_q == '1) ? hits_q : hits_q + 1'b1;

  assign stat_o.clearing     = clr_q;
  assign stat_o.release_bank = (st_q == SDone) && (!resv_q || out_ready_i);
  assign out_valid_o         = resv_q;
  assign out_data_o          = res_q;

  always_ff @(posedge clk_i) begin
    if (buf_wr_i.en) begin
      buf_mem[buf_wr_i.addr] <= buf_wr_i.data;
    end
    buf_rd <= buf_mem[buf_ra];
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd <= head_mem[rem_q];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      nxt_mem[used_q[EntW-1:0]]  <= head_q;
      elen_mem[used_q[EntW-1:0]] <= desc_q.len;
    end
    nxt_rd  <= nxt_mem[ent_ra];
    elen_rd <= elen_mem[ent_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      ecnt_mem[ent_ra] <= cnt_wd;
    end
    ecnt_rd <= ecnt_mem[ent_ra];
  end

  always_ff @(posedge clk_i) begin
    if (frm_we) begin
      frm_mem[{used_q[EntW-1:0], idx_q}] <= buf_rd;
    end
    frm_rd <= frm_mem[frm_ra];
  end

  always_comb begin
    st_d   = st_q;
    desc_d = desc_q;
    bkts_d = bkts_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    bit_d  = bit_q;
    head_d = head_q;
    cur_d  = cur_q;
    curv_d = curv_q;
    nxt_d  = nxt_q;
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    used_d = used_q;
    fused_d = fused_q;
    hits_d = hits_q;
    pend_d = pend_q;
    res_d  = res_q;
    resv_d = resv_q;
    clr_d  = clr_q;
    clra_d = clra_q;

    q_pop_o = 1'b0;
    buf_ra  = {desc_q.bank, idx_q};
    frm_ra  = {cur_q, idx_q};
    ent_ra  = cur_q;
    head_we = 1'b0;
    head_wa = rem_q;
    head_wd = {1'b1, used_q[EntW-1:0]};
    frm_we  = 1'b0;
    ent_we  = 1'b0;
    cnt_we  = 1'b0;
    cnt_wd  = 32'd1;

    if (resv_q && out_ready_i) begin
      resv_d = 1'b0;
    end

    if (clr_q) begin
      head_we = 1'b1;
      head_wa = clra_q;
      head_wd = '0;
      clra_d  = clra_q + 1'b1;
      if (clra_q == '1) begin
        clr_d = 1'b0;
      end
    end

    case (st_q)
      SIdle: begin
        if (q_valid_i && !clr_q) begin
          q_pop_o = 1'b1;
          desc_d  = q_data_i;
          dvd_d   = q_data_i.hash;
          rem_d   = '0;
          bit_d   = '0;
          if (bucket_count_i == '0) begin
            bkts_d = stdt_pkg::BcW'(1);
          end else if (bucket_count_i > stdt_pkg::BcW'(stdt_pkg::MaxBuckets)) begin
            bkts_d = stdt_pkg::BcW'(stdt_pkg::MaxBuckets);
          end else begin
            bkts_d = bucket_count_i;
          end
          st_d = SDiv;
        end
      end
      SDiv: begin
        rem_d = (trial >= bkts_q) ? trial_sub[BktW-1:0] : trial[BktW-1:0];
        dvd_d = {dvd_q[30:0], 1'b0};
        bit_d = bit_q + 1'b1;
        if (bit_q == '1) begin
          st_d = SHead;
        end
      end
      SHead: begin
        st_d = SHWait;
      end
      SHWait: begin
        head_d = head_rd;
        cur_d  = head_rd[EntW-1:0];
        curv_d = head_rd[EntW] && !desc_q.too_long;
        st_d   = SWalk;
      end
      SWalk: begin
        st_d = curv_q ? SEWait : SMiss;
      end
      SEWait: begin
        nxt_d = nxt_rd;
        cnt_d = ecnt_rd;
        idx_d = '0;
        if (elen_rd == desc_q.len) begin
          st_d = SCRd;
        end else begin
          cur_d  = nxt_rd[EntW-1:0];
          curv_d = nxt_rd[EntW];
          st_d   = SWalk;
        end
      end
      SCRd: begin
        st_d = SCChk;
      end
      SCChk: begin
        if (frm_rd != buf_rd) begin
          cur_d  = nxt_q[EntW-1:0];
          curv_d = nxt_q[EntW];
          st_d   = SWalk;
        end else if (last_idx) begin
          st_d = SHit;
        end else begin
          idx_d = idx_q + 1'b1;
          st_d  = SCRd;
        end
      end
      SHit: begin
        if (desc_q.kind == stdt_pkg::KindAdd) begin
          cnt_we = 1'b1;
          cnt_wd = cnt_inc;
        end
        hits_d              = hits_inc;
        pend_d.status       = stdt_pkg::StFound;
        pend_d.entry_index  = cur_q;
        pend_d.hit_count    = (desc_q.kind == stdt_pkg::KindAdd) ? cnt_inc : cnt_q;
        pend_d.trace_length = desc_q.len;
        pend_d.total_hits   = hits_inc;
        pend_d.total_traces = used_q;
        st_d                = SDone;
      end
      SMiss: begin
        pend_d.entry_index  = '0;
        pend_d.hit_count    = '0;
        pend_d.trace_length = desc_q.len;
        pend_d.total_hits   = hits_q;
        pend_d.total_traces = used_q;
        idx_d               = '0;
        if (desc_q.kind == stdt_pkg::KindFind) begin
          pend_d.status = stdt_pkg::StNotFound;
          st_d          = SDone;
        end else if (fail) begin
          pend_d.status = stdt_pkg::StFailed;
          st_d          = SDone;
        end else begin
          st_d = SCpRd;
        end
      end
      SCpRd: begin
        st_d = SCpWr;
      end
      SCpWr: begin
        frm_we = 1'b1;
        if (last_idx) begin
          st_d = SIns;
        end else begin
          idx_d = idx_q + 1'b1;
          st_d  = SCpRd;
        end
      end
      SIns: begin
        ent_ra  = used_q[EntW-1:0];
        ent_we  = 1'b1;
        cnt_we  = 1'b1;
        head_we = 1'b1;
        used_d  = used_q + 1'b1;
        fused_d = fsum[stdt_pkg::FlW-1:0];
        pend_d.status       = stdt_pkg::StAdded;
        pend_d.entry_index  = used_q[EntW-1:0];
        pend_d.hit_count    = 32'd1;
        pend_d.total_traces = used_q + 1'b1;
        st_d                = SDone;
      end
      SDone: begin
        if (!resv_q || out_ready_i) begin
          res_d  = pend_q;
          resv_d = 1'b1;
          st_d   = SIdle;
        end
      end
      default: begin
        st_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= SIdle;
      used_q  <= '0;
      fused_q <= '0;
      hits_q  <= '0;
      resv_q  <= 1'b0;
      clr_q   <= 1'b1;
      clra_q  <= '0;
    end else begin
      st_q    <= st_d;
      used_q  <= used_d;
      fused_q <= fused_d;
      hits_q  <= hits_d;
      resv_q  <= resv_d;
      clr_q   <= clr_d;
      clra_q  <= clra_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    bkts_q <= bkts_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    bit_q  <= bit_d;
    head_q <= head_d;
    cur_q  <= cur_d;
    curv_q <= curv_d;
    nxt_q  <= nxt_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    pend_q <= pend_d;
    res_q  <= res_d;
  end

endmodule

### sv/stack_trace_dedup_table.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   in_data_i (kind, frame, last)
// out       output     out_valid_o/out_ready_i out_data_o (status ... total_traces)
// cfg       input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// A frame item is taken while a trace buffer is free and no clearing pass runs; two
// trace buffers let the next trace gather while the previous one is looked up.
// A trace end goes through a bit-serial modulo and a bucket head read, then a chain walk
// that compares frames per entry and copies them for a new entry; the chain walk sets the rate.
// After reset a clearing pass empties all 1024 bucket heads and holds off input.
// A stalled output holds its item while frames arrive until both trace buffers are in use.
module stack_trace_dedup_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  stdt_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output stdt_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [stdt_pkg::CfgW-1:0]     cfg_wdata_i
);

  // Configuration registers: bucket count and the total frame budget.
  logic [stdt_pkg::BcW-1:0] bcount_q;
  logic [stdt_pkg::FlW-1:0] flimit_q;

  stdt_pkg::back_stat_t back_stat;
  stdt_pkg::buf_wr_t    buf_wr;
  stdt_pkg::desc_t      push_data, q_data;
  logic                 push, q_valid, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcount_q <= stdt_pkg::BcW'(stdt_pkg::MaxBuckets);
      flimit_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == stdt_pkg::CfgBucketCount) begin
        bcount_q <= cfg_wdata_i[stdt_pkg::BcW-1:0];
      end else begin
        flimit_q <= cfg_wdata_i[stdt_pkg::FlW-1:0];
      end
    end
  end

  // The front gathers frames and the running hash, and hands each finished
  // trace to the queue.
  stdt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .back_stat_i (back_stat),
    .buf_wr_o    (buf_wr),
    .push_o      (push),
    .push_data_o (push_data)
  );

  stdt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  // The back reduces the hash, walks the chain and inserts or counts.
  stdt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bucket_count_i (bcount_q),
    .frame_limit_i  (flimit_q),
    .buf_wr_i       (buf_wr),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .q_pop_o        (q_pop),
    .stat_o         (back_stat),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o)
  );

  a_traces_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.total_traces <= 10'd512)
    else $error("stored trace count beyond pool size");

  a_added_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == stdt_pkg::StAdded |-> out_data_o.hit_count == 32'd1)
    else $error("new entry without count of one");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == stdt_pkg::StNotFound ||
                    out_data_o.status == stdt_pkg::StFailed)
    |-> out_data_o.entry_index == 9'd0 && out_data_o.hit_count == 32'd0)
    else $error("miss carries entry fields");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.clearing |-> !in_ready_o && !q_pop)
    else $error("item taken during clearing pass");

endmodule

### tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Software copy of the dedup table. Each accepted frame item is folded into
  // the table, and a trace end queues the lookup answer that the block owes.
  class dedup_scoreboard;
    logic [10:0]         bucket_cnt;
    logic [14:0]         frame_lim;
    logic [31:0]         inc_frames[stdt_pkg::MaxDepth];
    int unsigned         inc_len;
    logic [31:0]         run_hash;
    bit                  too_long;
    bit                  head_valid[stdt_pkg::MaxBuckets];
    int unsigned         head[stdt_pkg::MaxBuckets];
    bit                  nxt_valid[stdt_pkg::MaxEntries];
    int unsigned         nxt[stdt_pkg::MaxEntries];
    int unsigned         e_len[stdt_pkg::MaxEntries];
    logic [31:0]         e_cnt[stdt_pkg::MaxEntries];
    logic [31:0]         e_frames[stdt_pkg::MaxEntries*stdt_pkg::MaxDepth];
    int unsigned         entries_used;
    int unsigned         frames_used;
    logic [31:0]         hits;
    stdt_pkg::out_item_t owed_results[$];
    int                  errors;

    function new();
      bucket_cnt = 11'(stdt_pkg::MaxBuckets);
      frame_lim = '0;
      inc_len = 0;
      run_hash = '0;
      too_long = 0;
      foreach (head_valid[i]) head_valid[i] = 0;
      entries_used = 0;
      frames_used = 0;
      hits = '0;
      errors = 0;
    endfunction

    function bit same_trace(int unsigned slot);
      if (e_len[slot] != inc_len) return 0;
      for (int unsigned i = 0; i < inc_len; i++)
        if (e_frames[slot*stdt_pkg::MaxDepth+i] != inc_frames[i]) return 0;
      return 1;
    endfunction

    function void note_item(stdt_pkg::in_item_t it);
      int unsigned bkts, bkt, slot, len, cur, steps;
      bit hit, v;
      stdt_pkg::out_item_t r;
      run_hash += {16'b0, it.frame[15:0] ^ it.frame[31:16]};
      if (inc_len < stdt_pkg::MaxDepth) begin
        inc_frames[inc_len] = it.frame;
        inc_len++;
      end else begin
        too_long = 1;
      end
      if (!it.last) return;

      // A zero bucket count acts as one, and a count past the table as the full table.
      bkts = (bucket_cnt == 0) ? 1 :
             ((bucket_cnt > stdt_pkg::MaxBuckets) ? stdt_pkg::MaxBuckets : bucket_cnt);
      bkt = run_hash % bkts;
      len = inc_len;
      hit = 0;
      slot = 0;
      if (!too_long) begin
        v = head_valid[bkt];
        cur = head[bkt];
        steps = 0;
        while (v && steps < stdt_pkg::MaxEntries && !hit) begin
          if (same_trace(cur)) begin
            hit = 1;
            slot = cur;
          end else begin
            v = nxt_valid[cur];
            cur = nxt[cur];
            steps++;
          end
        end
      end

      r = '0;
      r.trace_length = 6'(len);
      if (hit) begin
        if (it.kind == stdt_pkg::KindAdd && e_cnt[slot] != '1) e_cnt[slot]++;
        if (hits != '1) hits++;
        r.status = stdt_pkg::StFound;
        r.entry_index = 9'(slot);
        r.hit_count = e_cnt[slot];
      end else if (it.kind == stdt_pkg::KindFind) begin
        r.status = stdt_pkg::StNotFound;
      end else if (too_long || entries_used >= stdt_pkg::MaxEntries ||
                   (frame_lim != 0 && frames_used + len > frame_lim)) begin
        r.status = stdt_pkg::StFailed;
      end else begin
        slot = entries_used;
        for (int unsigned i = 0; i < len; i++)
          e_frames[slot*stdt_pkg::MaxDepth+i] = inc_frames[i];
        e_len[slot] = len;
        e_cnt[slot] = 32'd1;
        nxt_valid[slot] = head_valid[bkt];
        nxt[slot] = head[bkt];
        head_valid[bkt] = 1;
        head[bkt] = slot;
        entries_used++;
        frames_used += len;
        r.status = stdt_pkg::StAdded;
        r.entry_index = 9'(slot);
        r.hit_count = 32'd1;
      end
      r.total_hits = hits;
      r.total_traces = 10'(entries_used);
      owed_results.push_back(r);
      inc_len = 0;
      run_hash = '0;
      too_long = 0;
    endfunction

    function void check_result(stdt_pkg::out_item_t got);
      stdt_pkg::out_item_t want;
      if (owed_results.size() == 0) begin
        $error("result item with no lookup outstanding: %p", got);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.entry_index !== want.entry_index) begin
        $error("entry_index: expected %0d, got %0d", want.entry_index, got.entry_index);
        errors++;
      end
      if (got.hit_count !== want.hit_count) begin
        $error("hit_count: expected %0d, got %0d", want.hit_count, got.hit_count);
        errors++;
      end
      if (got.trace_length !== want.trace_length) begin
        $error("trace_length: expected %0d, got %0d", want.trace_length, got.trace_length);
        errors++;
      end
      if (got.total_hits !== want.total_hits) begin
        $error("total_hits: expected %0d, got %0d", want.total_hits, got.total_hits);
        errors++;
      end
      if (got.total_traces !== want.total_traces) begin
        $error("total_traces: expected %0d, got %0d", want.total_traces, got.total_traces);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  stdt_pkg::in_item_t        in_data_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  stdt_pkg::out_item_t       out_data_o;
  logic                      cfg_we_i;
  logic                      cfg_idx_i;
  logic [stdt_pkg::CfgW-1:0] cfg_wdata_i;

  stack_trace_dedup_table DUT (.*);

  dedup_scoreboard table_model = new();

  // Stall controls: no_idle turns off random receiver stalls and sender gaps, hold_req asks for one
  // long stall so the block backs up into both trace buffers.
  bit no_idle = 0;
  bit hold_req = 0;
  int frames_sent = 0;

  // Library of earlier traces, replayed so that finds and repeated adds hit.
  logic [31:0] lib_frames[64][36];
  int          lib_len[64];
  int          lib_fill = 0;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Both channels are observed at the rising edge, before the block's
  // registers move, so the sample does not depend on event order.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) table_model.note_item(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) table_model.check_result(out_data_o);
  end

  // Result receiver: random stalls, plus a counted long hold on request.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_req = 0;
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(99) >= 35);
      end
    end
  end

  // Offers one frame item and returns on the falling edge after it is taken.
  task automatic send_frame(logic kind, logic [31:0] frame, logic last);
    if (!no_idle && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{kind: kind, frame: frame, last: last};
    do @(posedge clk_i); while (!in_ready_o);
    frames_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_trace(logic kind, logic [31:0] frames[36], int len);
    for (int i = 0; i < len; i++) send_frame(kind, frames[i], i == len - 1);
  endtask

  // Lets the block finish every outstanding lookup.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (table_model.owed_results.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic idx, int unsigned value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value[stdt_pkg::CfgW-1:0];
    if (idx == stdt_pkg::CfgBucketCount) table_model.bucket_cnt = value[10:0];
    else table_model.frame_lim = value[14:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One random trace: mostly short, some deep, a few past the depth limit.
  // Half the time an earlier trace is replayed so the chains see hits.
  task automatic random_trace();
    logic [31:0] fr[36];
    int len, pick, sel;
    pick = $urandom_range(99);
    if (lib_fill > 0 && pick < 50) begin
      sel = $urandom_range(lib_fill - 1);
      len = lib_len[sel];
      fr = lib_frames[sel];
    end else begin
      sel = $urandom_range(99);
      len = (sel < 80) ? $urandom_range(1, 6) :
            (sel < 95) ? $urandom_range(7, stdt_pkg::MaxDepth) :
                         $urandom_range(stdt_pkg::MaxDepth + 1, 36);
      foreach (fr[i]) begin
        case ($urandom_range(9))
          0: fr[i] = '0;
          1: fr[i] = '1;
          2: fr[i] = $urandom_range(15);
          default: fr[i] = $urandom;
        endcase
      end
      if (lib_fill < 64) begin
        sel = lib_fill;
        lib_fill++;
      end else begin
        sel = $urandom_range(63);
      end
      lib_frames[sel] = fr;
      lib_len[sel] = len;
    end
    send_trace($urandom_range(1) ? stdt_pkg::KindAdd : stdt_pkg::KindFind, fr, len);
  endtask

  task automatic random_phase(int n_items);
    int stop;
    stop = frames_sent + n_items;
    while (frames_sent < stop) random_trace();
  endtask

  initial begin
    logic [31:0] fr[36];
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = stdt_pkg::CfgBucketCount;
    cfg_wdata_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with reset settings: extreme frames, add then find, a
    // repeated add, a full-depth trace, an over-deep trace that is dropped,
    // a find of something never stored, and two traces sharing a bucket.
    fr[0] = '0;
    send_trace(stdt_pkg::KindAdd, fr, 1);
    send_trace(stdt_pkg::KindFind, fr, 1);
    send_trace(stdt_pkg::KindAdd, fr, 1);
    fr[0] = '1;
    send_trace(stdt_pkg::KindAdd, fr, 1);
    foreach (fr[i]) fr[i] = 32'h1234_0000 + i;
    send_trace(stdt_pkg::KindAdd, fr, stdt_pkg::MaxDepth);
    send_trace(stdt_pkg::KindFind, fr, stdt_pkg::MaxDepth);
    send_trace(stdt_pkg::KindAdd, fr, stdt_pkg::MaxDepth + 1);
    send_trace(stdt_pkg::KindFind, fr, stdt_pkg::MaxDepth + 1);
    fr[0] = 32'hDEAD_BEEF;
    send_trace(stdt_pkg::KindFind, fr, 1);
    // Both frames hash to one, so they land in the same bucket.
    fr[0] = 32'h0000_0001;
    send_trace(stdt_pkg::KindAdd, fr, 1);
    fr[0] = 32'h0001_0000;
    send_trace(stdt_pkg::KindAdd, fr, 1);
    send_trace(stdt_pkg::KindFind, fr, 1);
    fr[0] = 32'h0000_0001;
    send_trace(stdt_pkg::KindFind, fr, 1);

    // One bucket: every trace shares a single long chain.
    write_cfg(stdt_pkg::CfgBucketCount, 1);
    random_phase(60);
    hold_req = 1;
    random_phase(60);
    no_idle = 1;
    random_phase(80);
    no_idle = 0;

    // A zero count acts as one bucket, and an oversize count as the full table.
    write_cfg(stdt_pkg::CfgBucketCount, 0);
    random_phase(50);
    write_cfg(stdt_pkg::CfgBucketCount, 2047);
    random_phase(50);

    // Tight frame budget: adds past it must fail. A bucket count change
    // leaves old chains in place, so some stored traces go missing.
    write_cfg(stdt_pkg::CfgBucketCount, 7);
    write_cfg(stdt_pkg::CfgFrameLimit, table_model.frames_used + 20);
    random_phase(40);
    drain();
    random_phase(40);
    write_cfg(stdt_pkg::CfgFrameLimit, 1);
    random_phase(20);

    // Fill the entry pool with one-frame traces, then show adds failing.
    write_cfg(stdt_pkg::CfgBucketCount, stdt_pkg::MaxBuckets);
    write_cfg(stdt_pkg::CfgFrameLimit, 32767);
    while (table_model.entries_used < stdt_pkg::MaxEntries) begin
      fr[0] = $urandom;
      send_trace(stdt_pkg::KindAdd, fr, 1);
    end
    random_phase(30);
    write_cfg(stdt_pkg::CfgFrameLimit, 0);
    random_phase(20);

    drain();
    repeat (100) @(negedge clk_i);
    if (table_model.errors == 0 && table_model.owed_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
